[sv/dic_pkg.sv]
// Shared types, codes and sizes for the disjoint interval coalescer.
`timescale 1ns / 1ps
package dic_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int VALUE_BITS    = 16;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_W-1:0]      t_count;

    localparam t_value VALUE_MAX = '1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_EXT_END   = 3'd1,
        ST_EXT_START = 3'd2,
        ST_JOIN      = 3'd3,
        ST_COVER     = 3'd4,
        ST_FULL      = 3'd5,
        ST_INTERVAL  = 3'd6,
        ST_EMPTY     = 3'd7
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        C_HOLD,
        C_CMP,
        C_NEW,
        C_EXT_END,
        C_EXT_START,
        C_JOIN,
        C_ROT
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_UPD,
        S_RD
    } t_state;

    typedef struct packed {
        logic   valid;
        t_value lower;
        t_value upper;
    } t_ival;

    // Per-cell compare results against the value under work.
    typedef struct packed {
        logic le;    // valid and lower <= value
        logic cov;   // upper >= value
        logic tl;    // upper == value - 1
        logic th;    // lower == value + 1
    } t_flags;

endpackage

[sv/dic_cell.sv]
// One cell of the interval chain: holds one interval and its compare flags.
`timescale 1ns / 1ps
module dic_cell
    import dic_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_value i_value,
    input  t_ival  i_left,
    input  t_ival  i_right,
    input  t_ival  i_head,
    input  logic   i_le_left,
    input  logic   i_le_right,
    output t_ival  o_ival,
    output t_flags o_flags
);

    logic   r_valid, n_valid;
    t_value r_lower, n_lower;
    t_value r_upper, n_upper;
    t_flags r_flags, n_flags;
    logic   is_lo;
    logic   is_pos;

    always_comb begin
        n_valid = r_valid;
        n_lower = r_lower;
        n_upper = r_upper;
        n_flags = r_flags;
        // lo: last cell at or below the value; pos: first cell above it
        is_lo   = r_flags.le && !i_le_right;
        is_pos  = !r_flags.le && i_le_left;
        case (i_cmd)
            C_CMP: begin
                n_flags.le  = r_valid && (r_lower <= i_value);
                n_flags.cov = (r_upper >= i_value);
                n_flags.tl  = r_valid && (i_value != '0)
                              && (r_upper == t_value'(i_value - t_value'(1)));
                n_flags.th  = r_valid && (i_value != VALUE_MAX)
                              && (r_lower == t_value'(i_value + t_value'(1)));
            end
            C_NEW: begin
                if (!r_flags.le) begin
                    if (i_le_left) begin
                        n_valid = 1'b1;
                        n_lower = i_value;
                        n_upper = i_value;
                    end else begin
                        n_valid = i_left.valid;
                        n_lower = i_left.lower;
                        n_upper = i_left.upper;
                    end
                end
            end
            C_EXT_END: begin
                if (is_lo) begin
                    n_upper = i_value;
                end
            end
            C_EXT_START: begin
                if (is_pos && r_valid) begin
                    n_lower = i_value;
                end
            end
            C_JOIN: begin
                if (is_lo) begin
                    n_upper = i_right.upper;
                end else if (!r_flags.le) begin
                    n_valid = i_right.valid;
                    n_lower = i_right.lower;
                    n_upper = i_right.upper;
                end
            end
            C_ROT: begin
                if (r_valid) begin
                    if (i_right.valid) begin
                        n_lower = i_right.lower;
                        n_upper = i_right.upper;
                    end else begin
                        n_lower = i_head.lower;
                        n_upper = i_head.upper;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lower <= n_lower;
        r_upper <= n_upper;
        r_flags <= n_flags;
    end

    assign o_ival  = '{valid: r_valid, lower: r_lower, upper: r_upper};
    assign o_flags = r_flags;

endmodule

[sv/dic_decide.sv]
// Resolves neighbor roles across the chain and picks the add outcome.
`timescale 1ns / 1ps
module dic_decide
    import dic_pkg::*;
(
    input  t_ival   i_ival  [MAX_INTERVALS],
    input  t_flags  i_flags [MAX_INTERVALS],
    input  t_value  i_value,
    output t_status o_status,
    output t_value  o_start,
    output t_value  o_end
);

    logic   covered;
    logic   touch_lo;
    logic   touch_hi;
    logic   is_lo;
    logic   is_hi;
    logic   le_left;
    logic   le_right;
    t_value lo_lower;
    t_value lo_upper;
    t_value hi_upper;

    always_comb begin
        covered  = 1'b0;
        touch_lo = 1'b0;
        touch_hi = 1'b0;
        lo_lower = '0;
        lo_upper = '0;
        hi_upper = '0;
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            le_left  = (i == 0) ? 1'b1 : i_flags[(i == 0) ? 0 : i - 1].le;
            le_right = (i == MAX_INTERVALS - 1) ? 1'b0
                       : i_flags[(i == MAX_INTERVALS - 1) ? i : i + 1].le;
            is_lo    = i_flags[i].le && !le_right;
            is_hi    = i_ival[i].valid && !i_flags[i].le && le_left;
            covered  = covered  | (is_lo & i_flags[i].cov);
            touch_lo = touch_lo | (is_lo & i_flags[i].tl);
            touch_hi = touch_hi | (is_hi & i_flags[i].th);
            lo_lower = lo_lower | ({VALUE_BITS{is_lo}} & i_ival[i].lower);
            lo_upper = lo_upper | ({VALUE_BITS{is_lo}} & i_ival[i].upper);
            hi_upper = hi_upper | ({VALUE_BITS{is_hi}} & i_ival[i].upper);
        end

        if (covered) begin
            o_status = ST_COVER;
            o_start  = lo_lower;
            o_end    = lo_upper;
        end else if (touch_lo && touch_hi) begin
            o_status = ST_JOIN;
            o_start  = lo_lower;
            o_end    = hi_upper;
        end else if (touch_lo) begin
            o_status = ST_EXT_END;
            o_start  = lo_lower;
            o_end    = i_value;
        end else if (touch_hi) begin
            o_status = ST_EXT_START;
            o_start  = i_value;
            o_end    = hi_upper;
        end else if (i_ival[MAX_INTERVALS-1].valid) begin
            o_status = ST_FULL;
            o_start  = i_value;
            o_end    = i_value;
        end else begin
            o_status = ST_NEW;
            o_start  = i_value;
            o_end    = i_value;
        end
    end

endmodule

[sv/disjoint_interval_coalescer.sv]
// Top level: sorted table of disjoint intervals kept in a chain of cells.
// A command is accepted only in idle. An add then passes the compare, decide and
// update stages; its one result beat is loaded in the update stage, which waits for
// room at the output. A read emits one beat per interval (one empty beat if none),
// the chain rotating one cell per beat; each beat waits while the output is stalled.
// Synchronous active-low reset empties the table and clears all control state.
`timescale 1ns / 1ps
module disjoint_interval_coalescer
    import dic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  t_value      i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output t_value      o_range_start,
    output t_value      o_range_end,
    output logic        o_last
);

    t_state  r_state, n_state;
    t_value  r_value;
    t_count  r_count, n_count;
    t_count  r_rd_idx, n_rd_idx;

    // decision from the decide stage
    t_status r_dec_status;
    t_value  r_dec_start;
    t_value  r_dec_end;

    // output register
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_value  r_out_start, n_out_start;
    t_value  r_out_end, n_out_end;
    logic    r_out_last, n_out_last;

    t_cmd    cmd;
    logic    out_free;
    logic    rd_last;
    t_status dec_status;
    t_value  dec_start;
    t_value  dec_end;

    t_ival   cell_ival  [MAX_INTERVALS];
    t_flags  cell_flags [MAX_INTERVALS];

    // Chain of cells; cell 0 holds the lowest interval. The ends of the chain
    // see an empty neighbor: everything is "at or below" to the left of cell 0,
    // nothing to the right of the last cell.
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
        t_ival left_ival;
        t_ival right_ival;
        logic  le_left;
        logic  le_right;

        if (g == 0) begin : g_first
            assign left_ival = '0;
            assign le_left   = 1'b1;
        end else begin : g_mid_l
            assign left_ival = cell_ival[g-1];
            assign le_left   = cell_flags[g-1].le;
        end

        if (g == MAX_INTERVALS - 1) begin : g_last
            assign right_ival = '0;
            assign le_right   = 1'b0;
        end else begin : g_mid_r
            assign right_ival = cell_ival[g+1];
            assign le_right   = cell_flags[g+1].le;
        end

        dic_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_value    (r_value),
            .i_left     (left_ival),
            .i_right    (right_ival),
            .i_head     (cell_ival[0]),
            .i_le_left  (le_left),
            .i_le_right (le_right),
            .o_ival     (cell_ival[g]),
            .o_flags    (cell_flags[g])
        );
    end

    dic_decide u_decide (
        .i_ival   (cell_ival),
        .i_flags  (cell_flags),
        .i_value  (r_value),
        .o_status (dec_status),
        .o_start  (dec_start),
        .o_end    (dec_end)
    );

    // The output register takes a new beat when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    assign rd_last  = (t_count'(r_rd_idx + 1'b1) == r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_last   = r_out_last;
        cmd          = C_HOLD;
        case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
                if (i_valid) begin
                    n_state = (i_operation == OP_READ) ? S_RD : S_CMP;
                end
            end
            S_CMP: begin
                // every cell compares its interval against the value
                cmd     = C_CMP;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // hold until the result beat has room, then apply the edit
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_dec_status;
                    n_out_start  = r_dec_start;
                    n_out_end    = r_dec_end;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                    case (r_dec_status)
                        ST_NEW: begin
                            cmd     = C_NEW;
                            n_count = t_count'(r_count + 1'b1);
                        end
                        ST_EXT_END: begin
                            cmd = C_EXT_END;
                        end
                        ST_EXT_START: begin
                            cmd = C_EXT_START;
                        end
                        ST_JOIN: begin
                            cmd     = C_JOIN;
                            n_count = t_count'(r_count - 1'b1);
                        end
                        default: begin
                            cmd = C_HOLD;
                        end
                    endcase
                end
            end
            S_RD: begin
                // emit the head cell and rotate; after count steps the chain
                // is back in its original order
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!cell_ival[0].valid) begin
                        n_out_status = ST_EMPTY;
                        n_out_start  = '0;
                        n_out_end    = '0;
                        n_out_last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_out_status = ST_INTERVAL;
                        n_out_start  = cell_ival[0].lower;
                        n_out_end    = cell_ival[0].upper;
                        n_out_last   = rd_last;
                        cmd          = C_ROT;
                        n_rd_idx     = t_count'(r_rd_idx + 1'b1);
                        if (rd_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_value <= i_value;
        end
        if (r_state == S_DEC) begin
            r_dec_status <= dec_status;
            r_dec_start  <= dec_start;
            r_dec_end    <= dec_end;
        end
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_last   <= n_out_last;
    end

    // Accept only when idle; a finished beat may still wait at the output.
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_range_start = r_out_start;
    assign o_range_end   = r_out_end;
    assign o_last        = r_out_last;

endmodule

[sv/dic_checker.sv]
// Port-level checker for the disjoint interval coalescer, with its bind.
`timescale 1ns / 1ps
module dic_checker
    import dic_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_operation,
    input t_value     i_value,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input t_value     o_range_start,
    input t_value     o_range_end,
    input logic       o_last
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_range_start) && $stable(o_range_end) && $stable(o_last))
        else $error("stalled result beat changed");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    // every add result is a single beat
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_INTERVAL && o_status != ST_EMPTY |-> o_last)
        else $error("add result without last");

    // an empty read is one zero beat
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |->
            o_last && o_range_start == '0 && o_range_end == '0)
        else $error("malformed empty read beat");

    // new and dropped values report a single-value interval
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NEW || o_status == ST_FULL) |->
            o_range_start == o_range_end)
        else $error("new or dropped value not a single-value interval");

endmodule

bind disjoint_interval_coalescer dic_checker u_dic_checker (.*);

[test/disjoint_interval_coalescer_tb.sv]
// Self-checking testbench for the disjoint interval coalescer.
`timescale 1ns / 1ps
module disjoint_interval_coalescer_tb;
    import dic_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_BEAT = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int FILL_EVENS   = 36;

    // One input beat waiting to be offered; drain makes the sender wait
    // until every outstanding result has come back before offering it.
    typedef struct {
        logic   op;
        t_value value;
        bit     drain;
    } t_cmd_beat;

    // One expected result beat.
    typedef struct {
        t_status status;
        t_value  lo;
        t_value  hi;
        logic    is_last;
    } t_ival_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_operation = OP_ADD;
    t_value     i_value     = '0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_status;
    t_value     o_range_start;
    t_value     o_range_end;
    logic       o_last;

    t_cmd_beat    cmd_beats[$];
    t_ival_result expected_ivals[$];
    t_cmd_beat    next_beat;

    // Shadow copy of the interval table.
    t_value ival_lo [MAX_INTERVALS];
    t_value ival_hi [MAX_INTERVALS];
    int     ival_count = 0;

    int beats_sent    = 0;
    int total_beats   = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 52;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int fails         = 0;
    int cycles        = 0;
    int cursor        = 0;

    disjoint_interval_coalescer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop in case the block locks up.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic expect_ival(input t_status st, input t_value lo, input t_value hi,
                               input logic is_last);
        t_ival_result r;
        r.status  = st;
        r.lo      = lo;
        r.hi      = hi;
        r.is_last = is_last;
        expected_ivals = {expected_ivals, r};
    endtask

    // Update the shadow table with one accepted beat and queue the results
    // it must produce.
    task automatic apply_beat_to_table(input logic op, input t_value v);
        int pos;
        int k;
        bit has_lo;
        bit has_hi;
        bit touch_lo;
        bit touch_hi;
        if (op == OP_READ) begin
            if (ival_count == 0) begin
                expect_ival(ST_EMPTY, '0, '0, 1'b1);
            end else begin
                for (k = 0; k < ival_count; k++)
                    expect_ival(ST_INTERVAL, ival_lo[k], ival_hi[k], k == ival_count - 1);
            end
            return;
        end
        // pos: first interval that starts above the value
        pos = 0;
        while (pos < ival_count && ival_lo[pos] <= v)
            pos++;
        has_lo = pos > 0;
        has_hi = pos < ival_count;
        if (has_lo && ival_hi[pos-1] >= v) begin
            expect_ival(ST_COVER, ival_lo[pos-1], ival_hi[pos-1], 1'b1);
            return;
        end
        // Neither bound wraps: zero has no lower neighbor, all-ones no upper.
        touch_lo = has_lo && v != '0 && ival_hi[pos-1] == t_value'(v - 1'b1);
        touch_hi = has_hi && v != VALUE_MAX && ival_lo[pos] == t_value'(v + 1'b1);
        if (touch_lo && touch_hi) begin
            ival_hi[pos-1] = ival_hi[pos];
            for (k = pos; k < ival_count - 1; k++) begin
                ival_lo[k] = ival_lo[k+1];
                ival_hi[k] = ival_hi[k+1];
            end
            ival_count--;
            expect_ival(ST_JOIN, ival_lo[pos-1], ival_hi[pos-1], 1'b1);
        end else if (touch_lo) begin
            ival_hi[pos-1] = v;
            expect_ival(ST_EXT_END, ival_lo[pos-1], v, 1'b1);
        end else if (touch_hi) begin
            ival_lo[pos] = v;
            expect_ival(ST_EXT_START, v, ival_hi[pos], 1'b1);
        end else if (ival_count >= MAX_INTERVALS) begin
            // no room: drop the value, table unchanged
            expect_ival(ST_FULL, v, v, 1'b1);
        end else begin
            for (k = ival_count; k > pos; k--) begin
                ival_lo[k] = ival_lo[k-1];
                ival_hi[k] = ival_hi[k-1];
            end
            ival_lo[pos] = v;
            ival_hi[pos] = v;
            ival_count++;
            expect_ival(ST_NEW, v, v, 1'b1);
        end
    endtask

    task automatic queue_beat(input logic op, input t_value v, input bit drain = 1'b0);
        t_cmd_beat b;
        b.op    = op;
        b.value = v;
        b.drain = drain;
        cmd_beats = {cmd_beats, b};
    endtask

    task automatic queue_add(input int v, input bit drain = 1'b0);
        queue_beat(OP_ADD, t_value'(v), drain);
    endtask

    // The value of a read is ignored; randomize it so its bits still toggle.
    task automatic queue_read(input bit drain = 1'b0);
        queue_beat(OP_READ, t_value'($urandom), drain);
    endtask

    // Add the values of [base, base+width) in shuffled order; a broken window
    // stops halfway and leaves fragments behind.
    task automatic queue_window(input int base, input int width, input bit whole);
        t_value vals[$];
        t_value tmp;
        int     j;
        int     n;
        for (j = 0; j < width; j++)
            vals = {vals, t_value'(base + j)};
        for (j = width - 1; j > 0; j--) begin
            n       = $urandom_range(j, 0);
            tmp     = vals[j];
            vals[j] = vals[n];
            vals[n] = tmp;
        end
        n = whole ? width : width / 2;
        for (j = 0; j < n; j++)
            queue_add(int'(vals[j]));
    endtask

    // Fill the table with isolated values, overflow it, list it at full
    // size, then close every gap so the entries merge back together.
    task automatic queue_fill_and_merge(input int base);
        int k;
        queue_add(base, 1'b1);
        for (k = 1; k < FILL_EVENS; k++)
            queue_add(base + 2 * k);
        queue_read();
        queue_window(base, 2 * FILL_EVENS, 1'b1);
        queue_read();
    endtask

    task automatic queue_random_part();
        int r;
        int width;
        int base;
        int k;
        while (cmd_beats.size() < ITEM_TARGET) begin
            r = $urandom_range(99);
            width = $urandom_range(20, 4);
            if (r < 80) begin
                // continue next to the last window half the time so they can join
                if ($urandom_range(1) == 1 && cursor + 2 + width <= 65536)
                    base = cursor + $urandom_range(2, 0);
                else
                    base = $urandom_range(65536 - width, 0);
                queue_window(base, width, r < 70);
                cursor = base + width;
                for (k = $urandom_range(2, 0); k > 0; k--)
                    queue_add(base + $urandom_range(width - 1, 0));
                if ($urandom_range(99) < 60)
                    queue_read();
            end else if (r < 90) begin
                queue_read();
            end else begin
                queue_add($urandom_range(65535, 0));
            end
        end
    endtask

    // Driver: hold the beat while stalled, otherwise offer the next one
    // unless the sender idles this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_operation <= OP_ADD;
            i_value     <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_beat_to_table(i_operation, i_value);
                beats_sent = beats_sent + 1;
            end
            // three phases of idling: sender light, then receiver light, then none
            if (beats_sent < total_beats / 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 52;
            end else if (beats_sent < 2 * total_beats / 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!(i_valid && o_stall)) begin
                if (cmd_beats.size() > 0
                    && !(cmd_beats[0].drain && expected_ivals.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = cmd_beats.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= next_beat.op;
                    i_value     <= next_beat.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest
    // expectation, and drive the receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_ivals.size() == 0) begin
                    $error("result beat with nothing expected: status %0d [0x%h, 0x%h]",
                           o_status, o_range_start, o_range_end);
                    fails = fails + 1;
                end else begin
                    if (o_status !== expected_ivals[0].status) begin
                        $error("status: expected %0d, got %0d",
                               expected_ivals[0].status, o_status);
                        fails = fails + 1;
                    end
                    if (o_range_start !== expected_ivals[0].lo) begin
                        $error("range_start: expected 0x%h, got 0x%h",
                               expected_ivals[0].lo, o_range_start);
                        fails = fails + 1;
                    end
                    if (o_range_end !== expected_ivals[0].hi) begin
                        $error("range_end: expected 0x%h, got 0x%h",
                               expected_ivals[0].hi, o_range_end);
                        fails = fails + 1;
                    end
                    if (o_last !== expected_ivals[0].is_last) begin
                        $error("last: expected %0d, got %0d",
                               expected_ivals[0].is_last, o_last);
                        fails = fails + 1;
                    end
                    void'(expected_ivals.pop_front());
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        // Directed: empty read, both bounds, every add outcome but full, bit patterns.
        queue_read();
        queue_add(0);
        queue_add(0);
        queue_add(1);
        queue_add(3);
        queue_add(2);
        queue_add(65535);
        queue_add(65534);
        queue_add(65533);
        queue_add(100);
        queue_add(102);
        queue_add(101);
        queue_add(99);
        queue_add(103);
        queue_add(65535);
        queue_add(50);
        queue_add(51);
        queue_add(49);
        queue_add(32768);
        queue_read();
        queue_add(16'h5555);
        queue_add(16'hAAAA);
        queue_read();

        queue_fill_and_merge($urandom_range(30000, 1000));
        queue_random_part();
        total_beats = cmd_beats.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_beats.size() > 0 || i_valid)
            @(posedge i_clk);
        while (expected_ivals.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
